[rtl/sds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg
// Types, constants and small helpers shared by the sounding symbolizer.
// ----------------------------------------------------------------------------
package sds_pkg;

    // display unit codes
    localparam logic [1:0] UNIT_FEET   = 2'd0;
    localparam logic [1:0] UNIT_METRE  = 2'd1;
    localparam logic [1:0] UNIT_FATHOM = 2'd2;

    // configuration register indexes
    localparam logic CFG_UNIT   = 1'b0;
    localparam logic CFG_SAFETY = 1'b1;

    // token kinds
    localparam logic [1:0] KIND_DIGIT  = 2'd0;
    localparam logic [1:0] KIND_SWEPT  = 2'd1;
    localparam logic [1:0] KIND_UNREL  = 2'd2;
    localparam logic [1:0] KIND_ABOVE  = 2'd3;

    // digit position codes
    localparam logic [2:0] POS_0 = 3'd0;
    localparam logic [2:0] POS_1 = 3'd1;
    localparam logic [2:0] POS_2 = 3'd2;
    localparam logic [2:0] POS_3 = 3'd3;
    localparam logic [2:0] POS_4 = 3'd4;
    localparam logic [2:0] POS_5 = 3'd5;

    // Q16 unit factors
    localparam logic [17:0] Q16_FEET   = 18'd215013;
    localparam logic [17:0] Q16_FATHOM = 18'd35835;
    localparam logic [17:0] Q16_METRE  = 18'd65536;

    // widths
    localparam int MAG_W  = 24;   // clamped magnitude in cm
    localparam int SAFE_W = 17;
    localparam int A_W    = 26;   // hundredths of the display unit
    localparam int S_W    = 19;
    localparam int L_W    = 19;   // whole units

    // reciprocals for constant division
    localparam logic [25:0] RCP_100_32   = 26'd42949672;  // 2^32 / 100
    localparam logic [20:0] RCP_10_24    = 21'd1677721;   // 2^24 / 10
    localparam logic [17:0] RCP_100_24   = 18'd167772;
    localparam logic [14:0] RCP_1000_24  = 15'd16777;
    localparam logic [10:0] RCP_10000_24 = 11'd1677;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] pos;
        logic [3:0] val;
    } t_token;

    typedef struct packed {
        logic neg;
        logic swept;
        logic unrel;
        logic feet;
        logic deep;
        logic lt1k;
        logic lt3k1;
        logic lt10k;
        logic lt100k;
        logic lt1m;
    } t_ctl;

    // leading digit saturates at nine
    function automatic logic [3:0] sat9(input logic [15:0] q);
        return (q > 16'd9) ? 4'd9 : q[3:0];
    endfunction

    function automatic t_token mk_tok(input logic [1:0] kind, input logic [2:0] pos,
                                      input logic [3:0] val);
        t_token t;
        t.kind = kind;
        t.pos  = pos;
        t.val  = val;
        return t;
    endfunction

endpackage

[rtl/sounding_digit_symbolizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sounding_digit_symbolizer_top
// Turns one depth sounding into a run of sounding symbol tokens.
// ----------------------------------------------------------------------------
// channel   direction  handshake                       payload
// item in   in         i_start high, o_busy low        i_depth_cm, flags, quality
// tokens    out        o_valid strobe, no back-pressure o_deep_prefix .. o_last
// config    in         i_cfg_we, i_cfg_index           i_cfg_data
//
// An item passes seven register stages (clamp, unit multiply, rounding,
// divide by 100, digit multiplies, digit correction) and then a token buffer
// that sends one token a cycle, 1 to 7 tokens per item. The first token shows
// once the item leaves the last stage and is loaded into the buffer, which
// sets the sustained rate: it takes the next item only as it sends the last
// token of the current one. While a full buffer holds a finished item, the
// whole pipeline halts and o_busy is high; nothing is dropped. Synchronous
// reset clears the valids and buffer state and sets unit feet, safety 2000.
// ----------------------------------------------------------------------------
module sounding_digit_symbolizer_top #(
    parameter int DEPTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [DEPTH_BITS-1:0]  i_depth_cm,
    input  logic                   i_swept_flag,
    input  logic                   i_low_quality_flag,
    input  logic [3:0]             i_position_quality,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [16:0]            i_cfg_data,
    output logic                   o_valid,
    output logic                   o_deep_prefix,
    output logic [1:0]             o_token_kind,
    output logic [2:0]             o_digit_position,
    output logic [3:0]             o_digit_value,
    output logic                   o_last
);
    import sds_pkg::*;

    // configuration registers
    logic [1:0]        r_unit;
    logic [SAFE_W-1:0] r_safety;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit   <= UNIT_FEET;
            r_safety <= 17'd2000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_UNIT:   r_unit   <= i_cfg_data[1:0];
                CFG_SAFETY: r_safety <= i_cfg_data;
                default:    r_unit   <= r_unit;
            endcase
        end
    end

    // pipeline control
    logic       w_stall, w_adv, w_accept, w_free, w_load;
    logic [6:0] r_vld;

    assign w_stall  = r_vld[6] && !w_free;
    assign w_adv    = !w_stall;
    assign o_busy   = w_stall;
    assign w_accept = i_start && !w_stall;
    assign w_load   = r_vld[6] && w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[5:0], w_accept};
        end
    end

    // stage 1 inputs: clamp and magnitude
    logic signed [32:0] w_ext, w_cm;
    logic [32:0]        w_abs;
    t_ctl               w_ctl0;

    always_comb begin
        w_ext = 33'($signed(i_depth_cm));
        if (w_ext > 33'sd4000000) begin
            w_cm = 33'sd9999900;
        end else if (w_ext < -33'sd100000) begin
            w_cm = 33'sd0;
        end else begin
            w_cm = w_ext;
        end
        w_abs        = (w_cm <= 33'sd0) ? 33'(-w_cm) : 33'(w_cm);
        w_ctl0       = '0;
        w_ctl0.neg   = (w_cm <= 33'sd0);
        w_ctl0.swept = i_swept_flag;
        w_ctl0.unrel = i_low_quality_flag ||
                       (i_position_quality >= 4'd2 && i_position_quality <= 4'd9);
        w_ctl0.feet  = (r_unit == UNIT_FEET);
    end

    // unit factor
    logic [17:0] w_fac;
    always_comb begin
        unique case (r_unit)
            UNIT_FEET:   w_fac = Q16_FEET;
            UNIT_FATHOM: w_fac = Q16_FATHOM;
            default:     w_fac = Q16_METRE;
        endcase
    end

    // stage registers
    t_ctl              r1_ctl, r2_ctl, r3_ctl, r4_ctl, r5_ctl, r6_ctl, r7_ctl;
    logic [MAG_W-1:0]  r1_mag;
    logic [41:0]       r2_p;
    logic [34:0]       r2_sp;
    logic [A_W-1:0]    r3_a, r4_a;
    logic [51:0]       r4_prod;
    logic [L_W-1:0]    r5_l, r6_l;
    logic [6:0]        r5_frac, r6_frac, r7_frac;
    logic [3:0]        r5_tenth, r6_tenth, r7_tenth;
    logic [39:0]       r6_p10;
    logic [36:0]       r6_p100;
    logic [33:0]       r6_p1000;
    logic [29:0]       r6_p10000;
    logic [3:0]        r7_d0, r7_d1, r7_d2, r7_d3;
    logic [3:0]        r7_s1, r7_s2, r7_s3, r7_s4;

    // rounding and nudge
    logic [A_W-1:0] w_a;
    logic [S_W-1:0] w_s;
    assign w_a = r2_p[41:16] + A_W'(r2_p[15]) + A_W'(1);
    assign w_s = r2_sp[34:16] + S_W'(r2_sp[15]);

    // control flags added at stages 3 and 4
    t_ctl n3_ctl, n4_ctl;
    always_comb begin
        n3_ctl        = r2_ctl;
        n3_ctl.deep   = !r2_ctl.neg && (w_a > A_W'(w_s));
        n4_ctl        = r3_ctl;
        n4_ctl.lt1k   = r3_a < A_W'(1000);
        n4_ctl.lt3k1  = r3_a < A_W'(3100);
        n4_ctl.lt10k  = r3_a < A_W'(10000);
        n4_ctl.lt100k = r3_a < A_W'(100000);
        n4_ctl.lt1m   = r3_a < A_W'(1000000);
    end

    // divide by 100 correction
    logic [19:0]    w_q0;
    logic [26:0]    w_r0;
    logic [L_W-1:0] w_l;
    logic [6:0]     w_frac;
    logic [14:0]    w_t;
    always_comb begin
        w_q0 = r4_prod[51:32];
        w_r0 = 27'(r4_a) - 27'(w_q0) * 27'd100;
        if (w_r0 >= 27'd100) begin
            w_l    = L_W'(w_q0 + 20'd1);
            w_frac = 7'(w_r0 - 27'd100);
        end else begin
            w_l    = L_W'(w_q0);
            w_frac = 7'(w_r0);
        end
        w_t = ({8'd0, w_frac} * 15'd205) >> 11;
    end

    // decimal quotients with correction
    logic [19:0] w_q1, w_q2, w_q3, w_q4, w_r;
    always_comb begin
        w_q1 = 20'(r6_p10[39:24]);
        w_r  = 20'(r6_l) - w_q1 * 20'd10;
        if (w_r >= 20'd10) w_q1 = w_q1 + 20'd1;
        w_q2 = 20'(r6_p100[36:24]);
        w_r  = 20'(r6_l) - w_q2 * 20'd100;
        if (w_r >= 20'd100) w_q2 = w_q2 + 20'd1;
        w_q3 = 20'(r6_p1000[33:24]);
        w_r  = 20'(r6_l) - w_q3 * 20'd1000;
        if (w_r >= 20'd1000) w_q3 = w_q3 + 20'd1;
        w_q4 = 20'(r6_p10000[29:24]);
        w_r  = 20'(r6_l) - w_q4 * 20'd10000;
        if (w_r >= 20'd10000) w_q4 = w_q4 + 20'd1;
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ctl <= w_ctl0;
            r1_mag <= w_abs[MAG_W-1:0];

            r2_ctl <= r1_ctl;
            r2_p   <= 42'(r1_mag) * 42'(w_fac);
            r2_sp  <= 35'(r_safety) * 35'(w_fac);

            r3_ctl <= n3_ctl;
            r3_a   <= w_a;

            r4_ctl  <= n4_ctl;
            r4_a    <= r3_a;
            r4_prod <= 52'(r3_a) * 52'(RCP_100_32);

            r5_ctl   <= r4_ctl;
            r5_l     <= w_l;
            r5_frac  <= w_frac;
            r5_tenth <= w_t[3:0];

            r6_ctl    <= r5_ctl;
            r6_l      <= r5_l;
            r6_frac   <= r5_frac;
            r6_tenth  <= r5_tenth;
            r6_p10    <= 40'(r5_l) * 40'(RCP_10_24);
            r6_p100   <= 37'(r5_l) * 37'(RCP_100_24);
            r6_p1000  <= 34'(r5_l) * 34'(RCP_1000_24);
            r6_p10000 <= 30'(r5_l) * 30'(RCP_10000_24);

            r7_ctl   <= r6_ctl;
            r7_frac  <= r6_frac;
            r7_tenth <= r6_tenth;
            r7_d0    <= 4'(20'(r6_l) - w_q1 * 20'd10);
            r7_d1    <= 4'(w_q1 - w_q2 * 20'd10);
            r7_d2    <= 4'(w_q2 - w_q3 * 20'd10);
            r7_d3    <= 4'(w_q3 - w_q4 * 20'd10);
            r7_s1    <= sat9(w_q1[15:0]);
            r7_s2    <= sat9(w_q2[15:0]);
            r7_s3    <= sat9(w_q3[15:0]);
            r7_s4    <= sat9(w_q4[15:0]);
        end
    end

    // token list assembly
    t_token     w_tok [8];
    logic [3:0] w_n;
    logic [3:0] w_lr;
    logic       w_done;

    always_comb begin
        for (int k = 0; k < 8; k++) w_tok[k] = '0;
        w_n    = 4'd0;
        w_done = 1'b0;
        w_lr   = r7_d0 + 4'(r7_frac >= 7'd50);
        if (r7_ctl.swept) begin
            w_tok[w_n[2:0]] = mk_tok(KIND_SWEPT, POS_0, 4'd0); w_n = w_n + 4'd1;
        end
        if (r7_ctl.unrel) begin
            w_tok[w_n[2:0]] = mk_tok(KIND_UNREL, POS_0, 4'd0); w_n = w_n + 4'd1;
        end
        // under ten
        if (r7_ctl.lt1k) begin
            w_done = 1'b1;
            if (r7_ctl.feet && !r7_ctl.neg) begin
                if (w_lr < 4'd10) begin
                    w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_1, w_lr); w_n = w_n + 4'd1;
                end else begin
                    w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_1, 4'd1); w_n = w_n + 4'd1;
                    w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_0, 4'd0); w_n = w_n + 4'd1;
                end
            end else begin
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_1, r7_d0); w_n = w_n + 4'd1;
                if (r7_tenth != 4'd0) begin
                    w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_5, r7_tenth);
                    w_n = w_n + 4'd1;
                end
                if (r7_ctl.neg) begin
                    w_tok[w_n[2:0]] = mk_tok(KIND_ABOVE, POS_0, 4'd0); w_n = w_n + 4'd1;
                end
            end
        end
        // under thirty-one with a fraction
        if (!w_done && r7_ctl.lt3k1 && r7_frac != 7'd0) begin
            w_done = 1'b1;
            w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_2, r7_s1); w_n = w_n + 4'd1;
            w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_1, r7_d0); w_n = w_n + 4'd1;
            if (!r7_ctl.feet && r7_tenth != 4'd0) begin
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_5, r7_tenth); w_n = w_n + 4'd1;
            end
            if (r7_ctl.neg) begin
                w_tok[w_n[2:0]] = mk_tok(KIND_ABOVE, POS_0, 4'd0); w_n = w_n + 4'd1;
            end
        end
        if (!w_done) begin
            priority if (r7_ctl.lt10k) begin
                if (r7_ctl.neg) begin
                    w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_2, r7_s1); w_n = w_n + 4'd1;
                    w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_1, r7_d0); w_n = w_n + 4'd1;
                    w_tok[w_n[2:0]] = mk_tok(KIND_ABOVE, POS_0, 4'd0); w_n = w_n + 4'd1;
                end else begin
                    w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_1, r7_s1); w_n = w_n + 4'd1;
                    w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_0, r7_d0); w_n = w_n + 4'd1;
                end
            end else if (r7_ctl.neg || r7_ctl.lt100k) begin
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_2, r7_s2); w_n = w_n + 4'd1;
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_1, r7_d1); w_n = w_n + 4'd1;
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_0, r7_d0); w_n = w_n + 4'd1;
            end else if (r7_ctl.lt1m) begin
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_2, r7_s3); w_n = w_n + 4'd1;
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_1, r7_d2); w_n = w_n + 4'd1;
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_0, r7_d1); w_n = w_n + 4'd1;
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_4, r7_d0); w_n = w_n + 4'd1;
            end else begin
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_3, r7_s4); w_n = w_n + 4'd1;
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_2, r7_d3); w_n = w_n + 4'd1;
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_1, r7_d2); w_n = w_n + 4'd1;
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_0, r7_d1); w_n = w_n + 4'd1;
                w_tok[w_n[2:0]] = mk_tok(KIND_DIGIT, POS_4, r7_d0); w_n = w_n + 4'd1;
            end
        end
    end

    // token buffer, one token out per cycle
    t_token     r_tok [8];
    logic       r_act, r_deep;
    logic [2:0] r_idx, r_end;

    assign w_free = !r_act || (r_idx == r_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_idx <= '0;
            r_end <= '0;
        end else if (w_load) begin
            r_act <= 1'b1;
            r_idx <= '0;
            r_end <= 3'(w_n - 4'd1);
        end else if (r_act) begin
            if (r_idx == r_end) begin
                r_act <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tok  <= w_tok;
            r_deep <= r7_ctl.deep;
        end
    end

    // result ports
    t_token w_cur;
    assign w_cur            = r_tok[r_idx];
    assign o_valid          = r_act;
    assign o_deep_prefix    = r_deep;
    assign o_token_kind     = w_cur.kind;
    assign o_digit_position = w_cur.pos;
    assign o_digit_value    = w_cur.val;
    assign o_last           = (r_idx == r_end);

endmodule
